/* hdl/secded_pkg.sv */
// Shared types, constants and the check-matrix table for the 39/32 SEC-DED codec.
// Used by secded_core and secded_39_32_codec; depends on nothing else.

package secded_pkg;

  localparam int DATA_W = 32;
  localparam int CHK_W  = 7;
  localparam int CW_W   = DATA_W + CHK_W;

  // Operation carried in the input beat's tuser.
  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_t;

  // Result status carried in the output beat's tuser.
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_CORRECTED   = 2'd1,
    ST_UNCORRECTED = 2'd2
  } status_t;

  typedef struct packed {
    logic [CW_W-1:0]   code_out;
    logic [DATA_W-1:0] data_out;
    logic [CHK_W-1:0]  syndrome;
    status_t           status;
  } res_t;

  // Check-matrix column k belongs to codeword bit 38-k; bit r is check row r.
  // All columns have odd weight and are pairwise distinct.
  localparam logic [CHK_W-1:0] HCOL [0:CW_W-1] = '{
    7'h57, 7'h07, 7'h5B, 7'h6B, 7'h0B, 7'h73, 7'h13, 7'h23,
    7'h1C, 7'h2C, 7'h4C, 7'h34, 7'h54, 7'h64, 7'h68, 7'h38,
    7'h16, 7'h46, 7'h1A, 7'h2A, 7'h4A, 7'h32, 7'h52, 7'h62,
    7'h5D, 7'h6D, 7'h0D, 7'h75, 7'h15, 7'h25, 7'h29, 7'h79,
    7'h01, 7'h02, 7'h04, 7'h08, 7'h10, 7'h20, 7'h40
  };

  // Syndrome of a codeword: XOR of the columns of all set bits.
  function automatic logic [CHK_W-1:0] syndrome_of(input logic [CW_W-1:0] cw);
    logic [CHK_W-1:0] s;
    s = '0;
    for (int k = 0; k < CW_W; k++) begin
      if (cw[CW_W-1-k]) begin
        s = s ^ HCOL[k];
      end
    end
    return s;
  endfunction

endpackage

/* hdl/secded_core.sv */
// Combinational encode and decode/correct logic of the 39/32 SEC-DED codec.
// Depends on secded_pkg for the check-matrix table and the result struct.

module secded_core (
  input  secded_pkg::req_t                   req_type,
  input  logic [secded_pkg::DATA_W-1:0]      data_in,
  input  logic [secded_pkg::CW_W-1:0]        code_in,
  output secded_pkg::res_t                   res
);

  logic [secded_pkg::CHK_W-1:0] enc_par;
  logic [secded_pkg::CW_W-1:0]  enc_word;
  logic [secded_pkg::CHK_W-1:0] dec_syn;
  logic [secded_pkg::CW_W-1:0]  flip;

  // Encode: the parity is the syndrome of the data with zero check bits.
  // Check row r lands on codeword bit 6-r, so the parity is bit-reversed.
  always_comb begin
    enc_par  = secded_pkg::syndrome_of({data_in, {secded_pkg::CHK_W{1'b0}}});
    enc_word = {data_in, {secded_pkg::CHK_W{1'b0}}};
    for (int r = 0; r < secded_pkg::CHK_W; r++) begin
      enc_word[secded_pkg::CHK_W-1-r] = enc_par[r];
    end
  end

  // Decode: compare the syndrome against every column in parallel.
  // Columns are distinct and nonzero, so at most one bit is flipped.
  always_comb begin
    dec_syn = secded_pkg::syndrome_of(code_in);
    for (int k = 0; k < secded_pkg::CW_W; k++) begin
      flip[secded_pkg::CW_W-1-k] = (dec_syn == secded_pkg::HCOL[k]);
    end
  end

  // Select the result for the requested operation.
  always_comb begin
    res = '0;
    case (req_type)
      secded_pkg::REQ_ENCODE: begin
        res.code_out = enc_word;
        res.syndrome = '0;
        res.status   = secded_pkg::ST_OK;
      end
      secded_pkg::REQ_DECODE: begin
        res.code_out = code_in ^ flip;
        res.syndrome = dec_syn;
        if (dec_syn == '0) begin
          res.status = secded_pkg::ST_OK;
        end else if (|flip) begin
          res.status = secded_pkg::ST_CORRECTED;
        end else begin
          res.status = secded_pkg::ST_UNCORRECTED;
        end
      end
      default: begin
        res.code_out = code_in;
        res.status   = secded_pkg::ST_UNCORRECTED;
      end
    endcase
    res.data_out = res.code_out[secded_pkg::CW_W-1:secded_pkg::CHK_W];
  end

endmodule

/* hdl/secded_39_32_codec.sv */
// Top level of the 39/32 SEC-DED codec: input register, codec logic, result register.
// Depends on secded_pkg and secded_core.
//
// Usage:
//   Requests arrive on the s_axis stream. tuser selects the operation (0 encode,
//   1 decode); tdata carries the data word in bits 31..0 and the received
//   codeword in bits 70..32. Each request gives exactly one result beat on the
//   m_axis stream: tdata holds code_out (38..0), data_out (70..39) and the
//   syndrome (77..71); tuser holds the status (0 clean, 1 one bit corrected,
//   2 uncorrectable).
//   Throughput is one beat per cycle while the receiver keeps taking results. A
//   request accepted on s_axis is held in the input register; the encode or
//   syndrome/correct logic then feeds the result register, which presents the
//   result beat on m_axis until the receiver takes it.
//   When the receiver stalls, the result register holds its beat and the input
//   register still takes one more request; s_axis_tready drops only when both
//   registers are full, and no beat is lost or repeated.
//   The synchronous reset empties both registers; there is no other state and
//   no configuration.

module secded_39_32_codec (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // data_in [31:0], code_in [70:32], zero [71]
  input  logic        s_axis_tuser,   // req_type [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // code_out [38:0], data_out [70:39],
                                      // syndrome [77:71], zero [79:78]
  output logic [1:0]  m_axis_tuser    // status [1:0]
);

  localparam int DW = secded_pkg::DATA_W;
  localparam int CW = secded_pkg::CW_W;

  logic                  in_valid;
  secded_pkg::req_t      in_req;
  logic [DW-1:0]         in_data;
  logic [CW-1:0]         in_code;
  logic                  out_valid;
  secded_pkg::res_t      out_res;
  secded_pkg::res_t      core_res;
  logic                  out_ready;

  // The result register can load when it is empty or being drained.
  assign out_ready     = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_ready;

  // Valid flags of the two register stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  // Input register captures an accepted beat.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req  <= secded_pkg::req_t'(s_axis_tuser);
      in_data <= s_axis_tdata[DW-1:0];
      in_code <= s_axis_tdata[DW+CW-1:DW];
    end
  end

  secded_core u_core (
    .req_type (in_req),
    .data_in  (in_data),
    .code_in  (in_code),
    .res      (core_res)
  );

  // Result register loads when the input stage moves forward.
  always_ff @(posedge clk) begin
    if (in_valid && out_ready) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_res.syndrome, out_res.data_out, out_res.code_out};
  assign m_axis_tuser  = out_res.status;

`ifndef SYNTHESIS
  // A full input stage that can move forward shows up at the output next cycle.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_ready) |=> out_valid)
    else $error("input stage advanced but no result became valid");

  // A blocked input stage keeps its beat.
  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_ready) |=> in_valid)
    else $error("blocked input stage dropped its beat");

  // A clean result always has a zero syndrome.
  a_ok_syn: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status == secded_pkg::ST_OK) |-> (out_res.syndrome == '0))
    else $error("clean status with nonzero syndrome");

  // A corrected result comes from an odd-weight syndrome.
  a_corr_odd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status == secded_pkg::ST_CORRECTED) |-> (^out_res.syndrome))
    else $error("correction made for an even-weight syndrome");

  // The data field always mirrors the upper codeword bits.
  a_data_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.data_out == out_res.code_out[CW-1:secded_pkg::CHK_W]))
    else $error("data_out differs from code_out data bits");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the 39/32 SEC-DED codec: encode and decode beats
// with random bursts and receiver stalls, predicted by an in-bench model.
// Depends on secded_pkg and secded_39_32_codec.

module tb;

  // Check-matrix column of each codeword bit, indexed by bit position.
  localparam logic [6:0] BIT_COL [0:38] = '{
    7'h40, 7'h20, 7'h10, 7'h08, 7'h04, 7'h02, 7'h01,
    7'h79, 7'h29, 7'h25, 7'h15, 7'h75, 7'h0D, 7'h6D, 7'h5D,
    7'h62, 7'h52, 7'h32, 7'h4A, 7'h2A, 7'h1A, 7'h46, 7'h16,
    7'h38, 7'h68, 7'h64, 7'h54, 7'h34, 7'h4C, 7'h2C, 7'h1C,
    7'h23, 7'h13, 7'h73, 7'h0B, 7'h6B, 7'h5B, 7'h07, 7'h57
  };
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD = 300;

  typedef struct {
    secded_pkg::req_t op;
    logic [31:0]      data;
    logic [38:0]      code;
    bit               wait_drain;  // hold off until every earlier result has come back
  } codec_req_t;

  typedef struct {
    logic [38:0]         code;
    logic [31:0]         data;
    logic [6:0]          syn;
    secded_pkg::status_t st;
  } codec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // data_in [31:0], code_in [70:32], zero [71]
  logic        s_axis_tuser = 1'b0; // req_type [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // code_out [38:0], data_out [70:39], syndrome [77:71]
  logic [1:0]  m_axis_tuser;        // status [1:0]

  codec_req_t    codec_requests[$];
  codec_result_t awaited_results[$];
  int            mismatch_count = 0;

  secded_39_32_codec DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [6:0] word_syndrome(logic [38:0] cw);
    logic [6:0] s;
    s = '0;
    for (int b = 0; b < 39; b++) begin
      if (cw[b]) begin
        s ^= BIT_COL[b];
      end
    end
    return s;
  endfunction

  // Expected result of one request.
  function automatic codec_result_t predict_codec(codec_req_t r);
    codec_result_t res;
    logic [38:0] cw;
    logic [6:0] s;
    res.syn = '0;
    res.st = secded_pkg::ST_OK;
    if (r.op == secded_pkg::REQ_ENCODE) begin
      cw = {r.data, 7'b0};
      s = word_syndrome(cw);
      // Check row k lands in codeword bit 6-k.
      for (int k = 0; k < 7; k++) begin
        cw[6-k] = s[k];
      end
    end else begin
      cw = r.code;
      s = word_syndrome(cw);
      res.syn = s;
      if (s != 7'd0) begin
        res.st = secded_pkg::ST_UNCORRECTED;
        for (int b = 0; b < 39; b++) begin
          if (BIT_COL[b] == s) begin
            cw[b] = ~cw[b];
            res.st = secded_pkg::ST_CORRECTED;
          end
        end
      end
    end
    res.code = cw;
    res.data = cw[38:7];
    return res;
  endfunction

  function automatic logic [38:0] clean_word(logic [31:0] data);
    codec_req_t r;
    codec_result_t res;
    r.op = secded_pkg::REQ_ENCODE;
    r.data = data;
    r.code = '0;
    r.wait_drain = 1'b0;
    res = predict_codec(r);
    return res.code;
  endfunction

  function automatic logic [38:0] random_word39();
    logic [31:0] lo;
    logic [6:0] hi;
    lo = $urandom;
    hi = 7'($urandom_range(0, 127));
    return {hi, lo};
  endfunction

  // Flip the check bits that belong to the given check rows.
  function automatic logic [38:0] flip_rows(logic [38:0] cw, logic [6:0] rows);
    for (int k = 0; k < 7; k++) begin
      if (rows[k]) begin
        cw[6-k] = ~cw[6-k];
      end
    end
    return cw;
  endfunction

  task automatic add_request(secded_pkg::req_t op, logic [31:0] data, logic [38:0] code,
                             bit wait_drain);
    codec_req_t r;
    r.op = op;
    r.data = data;
    r.code = code;
    r.wait_drain = wait_drain;
    codec_requests.push_back(r);
  endtask

  // Driver: offers queued requests in bursts separated by random gaps.
  codec_req_t cur_req;
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(predict_codec(cur_req));
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (codec_requests.size() != 0 &&
                     !(codec_requests[0].wait_drain && awaited_results.size() != 0)) begin
          cur_req = codec_requests.pop_front();
          offer = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 30);
          end
        end
      end
      s_axis_tvalid <= offer;
      s_axis_tdata <= {1'b0, cur_req.code, cur_req.data};
      s_axis_tuser <= cur_req.op;
    end
  end

  // Receiver: stall pattern steps through four modes as rx_cycle advances, plus one long hold-off.
  int rx_cycle = 0;
  int beats_in = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    bit rdy;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        beats_in++;
      end
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!long_hold_done && beats_in >= 300) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        rdy = 1'b0;
      end else begin
        case ((rx_cycle >> 6) % 4)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 3) != 0);
          2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = rx_cycle[0];
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // Monitor: compares each result beat with the oldest prediction.
  always @(posedge clk) begin
    codec_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat with none expected, actual tdata %h tuser %0d",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tdata[38:0] !== want.code) begin
          $display("%0t: code_out expected %h actual %h", $time, want.code, m_axis_tdata[38:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[70:39] !== want.data) begin
          $display("%0t: data_out expected %h actual %h", $time, want.data, m_axis_tdata[70:39]);
          mismatch_count++;
        end
        if (m_axis_tdata[77:71] !== want.syn) begin
          $display("%0t: syndrome expected %h actual %h", $time, want.syn, m_axis_tdata[77:71]);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when neither side has moved a beat for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [31:0] d;
    logic [38:0] cw;
    int kind;
    int flips;
    bit drain;

    // Directed: field extremes, ignored fields, and each decode outcome.
    add_request(secded_pkg::REQ_ENCODE, 32'h0000_0000, '0, 1'b0);
    add_request(secded_pkg::REQ_ENCODE, 32'hFFFF_FFFF, '1, 1'b0);
    add_request(secded_pkg::REQ_ENCODE, 32'hAAAA_AAAA, random_word39(), 1'b0);
    add_request(secded_pkg::REQ_ENCODE, 32'h5555_5555, '0, 1'b0);
    add_request(secded_pkg::REQ_ENCODE, 32'h0000_0001, '0, 1'b0);
    add_request(secded_pkg::REQ_ENCODE, 32'h8000_0000, '0, 1'b0);
    add_request(secded_pkg::REQ_DECODE, 32'h0, '0, 1'b0);
    add_request(secded_pkg::REQ_DECODE, 32'hFFFF_FFFF, '1, 1'b0);
    add_request(secded_pkg::REQ_DECODE, 32'h0, clean_word(32'hFFFF_FFFF), 1'b0);
    d = $urandom;
    cw = clean_word(d);
    add_request(secded_pkg::REQ_DECODE, $urandom, cw, 1'b0);
    // Single errors in the top and bottom data bits and in check bits.
    add_request(secded_pkg::REQ_DECODE, 32'h0, cw ^ (39'd1 << 38), 1'b0);
    add_request(secded_pkg::REQ_DECODE, 32'h0, cw ^ (39'd1 << 7), 1'b0);
    add_request(secded_pkg::REQ_DECODE, 32'h0, cw ^ 39'd1, 1'b0);
    add_request(secded_pkg::REQ_DECODE, 32'h0, cw ^ (39'd1 << 6), 1'b0);
    add_request(secded_pkg::REQ_DECODE, 32'h0, clean_word(32'h0) ^ (39'd1 << 20), 1'b0);
    // Double errors give an even-weight syndrome.
    add_request(secded_pkg::REQ_DECODE, 32'h0, cw ^ (39'd1 << 38) ^ (39'd1 << 3), 1'b0);
    add_request(secded_pkg::REQ_DECODE, 32'h0, cw ^ (39'd1 << 15) ^ (39'd1 << 16), 1'b0);
    // Odd-weight syndromes that match no column.
    add_request(secded_pkg::REQ_DECODE, 32'h0, flip_rows(cw, 7'h7F), 1'b0);
    add_request(secded_pkg::REQ_DECODE, 32'h0, flip_rows(cw, 7'h0E), 1'b0);
    // Three check errors aliasing onto a data column.
    add_request(secded_pkg::REQ_DECODE, 32'h0, flip_rows(cw, 7'h07), 1'b0);

    // Random: half codewords with up to three errors, the rest raw words and encodes.
    for (int i = 0; i < 900; i++) begin
      kind = $urandom_range(0, 7);
      d = $urandom;
      drain = (i == 0) || ($urandom_range(0, 99) == 0);
      if (kind < 2) begin
        add_request(secded_pkg::REQ_ENCODE, d, random_word39(), drain);
      end else if (kind < 6) begin
        cw = clean_word(d);
        case ($urandom_range(0, 6))
          0: flips = 0;
          1, 2, 3: flips = 1;
          4, 5: flips = 2;
          default: flips = 3;
        endcase
        for (int f = 0; f < flips; f++) begin
          cw[$urandom_range(0, 38)] ^= 1'b1;
        end
        add_request(secded_pkg::REQ_DECODE, $urandom, cw, drain);
      end else begin
        add_request(secded_pkg::REQ_DECODE, $urandom, random_word39(), drain);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (codec_requests.size() != 0 || s_axis_tvalid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/secded_pkg.sv
hdl/secded_core.sv
hdl/secded_39_32_codec.sv
tb/sv/tb.sv
